[hw/rtl/spr_pkg.sv]
`default_nettype none

package spr_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 4;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    // Configuration register map.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES = 2'd0,
        REG_PATTERN_LEN   = 2'd1,
        REG_REPLACE_BYTES = 2'd2,
        REG_REPLACE_LEN   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_input;
    } t_in_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              run_last;
        logic              stream_done;
    } t_out_beat;

    // Side information that travels with a burst of result beats.
    typedef struct packed {
        logic eos;   // burst closes the stream
        logic mark;  // burst is the single empty end marker
    } t_burst_ctl;

endpackage

`default_nettype wire

[hw/rtl/spr_cfg.sv]
`default_nettype none

module spr_cfg
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_REPLACE = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr,
    input  wire logic [CFG_IDX_W-1:0] i_index,
    input  wire logic [CFG_W-1:0]     i_wdata,
    output logic      [CFG_W-1:0]     o_pattern,
    output logic      [CFG_W-1:0]     o_replace,
    output logic      [LEN_W-1:0]     o_plen,
    output logic      [LEN_W-1:0]     o_rlen,
    output logic                      o_win_clear
);

    logic [CFG_W-1:0] r_pattern;
    logic [CFG_W-1:0] r_replace;
    logic [LEN_W-1:0] r_plen;
    logic [LEN_W-1:0] r_rlen;
    logic [LEN_W-1:0] wr_len;
    logic [LEN_W-1:0] n_plen;
    logic [LEN_W-1:0] n_rlen;

    // Lengths are stored already clamped to their legal ranges.
    always_comb begin
        wr_len = i_wdata[LEN_W-1:0];
        if (wr_len == '0) begin
            n_plen = LEN_W'(1);
        end else if (wr_len > LEN_W'(MAX_PATTERN)) begin
            n_plen = LEN_W'(MAX_PATTERN);
        end else begin
            n_plen = wr_len;
        end
        if (wr_len > LEN_W'(MAX_REPLACE)) begin
            n_rlen = LEN_W'(MAX_REPLACE);
        end else begin
            n_rlen = wr_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_replace <= '0;
            r_plen    <= LEN_W'(1);
            r_rlen    <= '0;
        end else if (i_wr) begin
            unique case (t_cfg_reg'(i_index))
                REG_PATTERN_BYTES: r_pattern <= i_wdata;
                REG_PATTERN_LEN:   r_plen    <= n_plen;
                REG_REPLACE_BYTES: r_replace <= i_wdata;
                REG_REPLACE_LEN:   r_rlen    <= n_rlen;
                default: ;
            endcase
        end
    end

    assign o_pattern   = r_pattern;
    assign o_replace   = r_replace;
    assign o_plen      = r_plen;
    assign o_rlen      = r_rlen;
    assign o_win_clear = i_wr && (t_cfg_reg'(i_index) == REG_PATTERN_LEN);

endmodule

`default_nettype wire

[hw/rtl/spr_window.sv]
`default_nettype none

module spr_window
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN = 8,
    parameter int BURST_D     = 8,
    localparam int WCNT_W     = $clog2(MAX_PATTERN + 1),
    localparam int CNT_W      = $clog2(BURST_D + 1)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_take,
    input  wire t_in_beat                       i_data,
    input  wire logic                           i_win_clear,
    input  wire logic [CFG_W-1:0]               i_pattern,
    input  wire logic [CFG_W-1:0]               i_replace,
    input  wire logic [LEN_W-1:0]               i_plen,
    input  wire logic [LEN_W-1:0]               i_rlen,
    output logic      [BURST_D-1:0][BYTE_W-1:0] o_bytes,
    output logic      [CNT_W-1:0]               o_count,
    output t_burst_ctl                          o_ctl
);

    logic [BYTE_W-1:0] r_win [MAX_PATTERN];
    logic [WCNT_W-1:0] r_cnt;

    logic [BYTE_W-1:0] w_new [MAX_PATTERN];
    logic [BYTE_W-1:0] n_win [MAX_PATTERN];
    logic [WCNT_W-1:0] n_cnt;
    logic [LEN_W-1:0]  cnt_ext;
    logic [LEN_W-1:0]  base;
    logic [LEN_W-1:0]  c1;
    logic              full;
    logic              hit;
    logic              matched;
    logic              last;
    logic              mark;
    logic [CNT_W-1:0]  cnt_raw;

    always_comb begin
        last    = i_data.end_of_input;
        cnt_ext = LEN_W'(r_cnt);
        base    = (cnt_ext >= i_plen) ? '0 : cnt_ext;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            w_new[i] = (LEN_W'(i) == base) ? i_data.in_byte : r_win[i];
        end
        c1   = base + LEN_W'(1);
        full = (c1 == i_plen);

        hit = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (LEN_W'(i) < i_plen && w_new[i] != i_pattern[BYTE_W*i +: BYTE_W]) begin
                hit = 1'b0;
            end
        end
        matched = full && hit;

        // A final beat that does not match flushes the whole window, which
        // starts with the byte a plain mismatch would have sent.
        if (matched) begin
            cnt_raw = CNT_W'(i_rlen);
        end else if (last) begin
            cnt_raw = CNT_W'(c1);
        end else if (full) begin
            cnt_raw = CNT_W'(1);
        end else begin
            cnt_raw = '0;
        end
        mark    = last && (cnt_raw == '0);
        o_count = mark ? CNT_W'(1) : cnt_raw;

        for (int i = 0; i < MAX_PATTERN; i++) begin
            n_win[i] = (full && !matched) ? w_new[(i + 1 < MAX_PATTERN) ? i + 1 : i]
                                          : w_new[i];
        end

        if (last || matched) begin
            n_cnt = '0;
        end else if (full) begin
            n_cnt = WCNT_W'(i_plen - LEN_W'(1));
        end else begin
            n_cnt = WCNT_W'(c1);
        end
    end

    // The empty end marker carries a zero byte; it only comes from a final beat
    // that matches with an empty replacement.
    for (genvar g = 0; g < BURST_D; g++) begin : g_burst
        if (g < MAX_PATTERN) begin : g_win
            assign o_bytes[g] = mark ? '0
                              : (matched ? i_replace[BYTE_W*g +: BYTE_W] : w_new[g]);
        end else begin : g_rep
            assign o_bytes[g] = matched ? i_replace[BYTE_W*g +: BYTE_W] : '0;
        end
    end

    assign o_ctl.eos  = last;
    assign o_ctl.mark = mark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_win_clear) begin
            r_cnt <= '0;
        end else if (i_take) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_win <= n_win;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/spr_emit.sv]
`default_nettype none

module spr_emit
    import spr_pkg::*;
#(
    parameter int BURST_D   = 8,
    localparam int CNT_W    = $clog2(BURST_D + 1),
    localparam int IDX_W    = (BURST_D > 1) ? $clog2(BURST_D) : 1
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_take,
    input  wire logic [BURST_D-1:0][BYTE_W-1:0] i_bytes,
    input  wire logic [CNT_W-1:0]               i_count,
    input  wire t_burst_ctl                     i_ctl,
    input  wire logic                           i_stall,
    output logic                                o_valid,
    output t_out_beat                           o_data,
    output logic                                o_busy
);

    logic [BYTE_W-1:0] r_bb [BURST_D];
    logic [CNT_W-1:0]  r_rem;
    logic [IDX_W-1:0]  r_idx;
    t_burst_ctl        r_ctl;
    logic              r_oval;
    t_out_beat         r_out;

    logic              out_ready;
    logic              new_burst;
    t_out_beat         beat_buf;
    t_out_beat         beat_new;

    always_comb begin
        out_ready = !r_oval || !i_stall;
        new_burst = i_take && (i_count != '0);

        beat_buf.out_byte    = r_bb[r_idx];
        beat_buf.byte_valid  = !r_ctl.mark;
        beat_buf.run_last    = (r_rem == CNT_W'(1));
        beat_buf.stream_done = r_ctl.eos && (r_rem == CNT_W'(1));

        beat_new.out_byte    = i_bytes[0];
        beat_new.byte_valid  = !i_ctl.mark;
        beat_new.run_last    = (i_count == CNT_W'(1));
        beat_new.stream_done = i_ctl.eos && (i_count == CNT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
            r_rem  <= '0;
        end else begin
            if (out_ready) begin
                r_oval <= (r_rem != '0) || new_burst;
            end
            // A new burst only arrives while the buffer is empty; its first
            // beat goes straight to the output register when that is free.
            if (new_burst) begin
                r_rem <= out_ready ? i_count - CNT_W'(1) : i_count;
            end else if (r_rem != '0 && out_ready) begin
                r_rem <= r_rem - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            if (r_rem != '0) begin
                r_out <= beat_buf;
            end else if (new_burst) begin
                r_out <= beat_new;
            end
        end
        if (new_burst) begin
            for (int i = 0; i < BURST_D; i++) begin
                r_bb[i] <= i_bytes[i];
            end
            r_ctl <= i_ctl;
            r_idx <= out_ready ? IDX_W'(1) : '0;
        end else if (r_rem != '0 && out_ready) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    assign o_valid = r_oval;
    assign o_data  = r_out;
    assign o_busy  = (r_rem != '0);

endmodule

`default_nettype wire

[hw/rtl/stream_pattern_replace.sv]
`default_nettype none

// Streaming find-and-replace over a byte stream. Each input beat carries one
// byte and an end-of-input flag. The block keeps a window of the last
// unconsumed bytes, as many as the configured pattern length. When the window
// is full and equals the pattern, the replacement text (zero to MAX_REPLACE
// bytes) is sent and the window is emptied; when it is full and differs, its
// oldest byte is sent and the window shifts. The beat flagged as end of input
// flushes whatever remains; if that beat would produce nothing, a single empty
// end marker (byte_valid low) is sent instead. run_last marks the last output
// beat caused by one input beat and stream_done marks the final beat of the
// stream; after it a new stream starts with an empty window. Matching is
// leftmost and non-overlapping, and every byte value, zero included, compares
// as a plain byte. An input beat is taken whenever the burst buffer is empty,
// even while the output register holds a stalled beat, so a stream whose input
// beats each cause at most one output beat flows at one beat per clock
// while the output does not stall. An input beat that causes two or more output
// beats holds the input side stalled while the burst buffer drains one beat per
// cycle through the output register; downstream stalls add to that. Lengths
// written outside their ranges are clamped: a pattern length of zero counts as
// one. Writing the pattern length empties the window. Configuration writes are
// accepted at any time but are meant to happen only while the block is idle.

module stream_pattern_replace
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_REPLACE = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input byte stream.
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire t_in_beat             i_data,
    // Rewritten byte stream.
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output t_out_beat                 o_data,
    // Configuration writes.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    // One input beat yields at most a full window or a full replacement.
    localparam int BURST_D = (MAX_REPLACE > MAX_PATTERN) ? MAX_REPLACE : MAX_PATTERN;
    localparam int CNT_W   = $clog2(BURST_D + 1);

    logic [CFG_W-1:0]               pattern;
    logic [CFG_W-1:0]               replace;
    logic [LEN_W-1:0]               plen;
    logic [LEN_W-1:0]               rlen;
    logic                           win_clear;
    logic                           take;
    logic                           busy;
    logic [BURST_D-1:0][BYTE_W-1:0] burst_bytes;
    logic [CNT_W-1:0]               burst_count;
    t_burst_ctl                     burst_ctl;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = busy;
    assign take        = i_valid && !busy;

    spr_cfg #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_REPLACE (MAX_REPLACE)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (i_cfg_valid),
        .i_index     (i_cfg_index),
        .i_wdata     (i_cfg_data),
        .o_pattern   (pattern),
        .o_replace   (replace),
        .o_plen      (plen),
        .o_rlen      (rlen),
        .o_win_clear (win_clear)
    );

    // Window update and match: one input beat becomes one burst of results.
    spr_window #(
        .MAX_PATTERN (MAX_PATTERN),
        .BURST_D     (BURST_D)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data      (i_data),
        .i_win_clear (win_clear),
        .i_pattern   (pattern),
        .i_replace   (replace),
        .i_plen      (plen),
        .i_rlen      (rlen),
        .o_bytes     (burst_bytes),
        .o_count     (burst_count),
        .o_ctl       (burst_ctl)
    );

    // Burst buffer and output register.
    spr_emit #(
        .BURST_D (BURST_D)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_bytes (burst_bytes),
        .i_count (burst_count),
        .i_ctl   (burst_ctl),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .o_busy  (busy)
    );

endmodule

`default_nettype wire

[hw/rtl/spr_checker.sv]
`default_nettype none

module spr_checker
    import spr_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_valid,
    input wire logic      i_stall,
    input wire t_out_beat o_data
);

    // Nothing is shown in the first cycle after reset.
    a_quiet_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

    a_done_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.stream_done |-> o_data.run_last)
        else $error("stream_done without run_last");

    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.byte_valid |-> o_data.stream_done && o_data.out_byte == '0)
        else $error("malformed empty end marker");

    // The rest of a burst follows without a gap.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_data.run_last |=> o_valid)
        else $error("gap inside a burst");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled output beat changed");

endmodule

bind stream_pattern_replace spr_checker u_spr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire
